/* rtl/core/itrt_pkg.sv */
`timescale 1ns / 1ps

package itrt_pkg;

  // sizes of the number and the digit store
  localparam int unsigned ValueWidth     = 64;
  localparam int unsigned RadixWidth     = 5;
  localparam int unsigned DigitWidth     = 4;
  localparam int unsigned DigitDepth     = 64;
  localparam int unsigned DigitAddrWidth = 6;
  localparam int unsigned CountWidth     = 7;

  // radix limits and ascii codes
  localparam logic [RadixWidth-1:0] RadixMin   = 5'd2;
  localparam logic [RadixWidth-1:0] RadixMax   = 5'd16;
  localparam logic [RadixWidth-1:0] RadixDec   = 5'd10;
  localparam logic [7:0]            CharMinus  = 8'h2D;
  localparam logic [7:0]            CharZero   = 8'h30;
  localparam logic [7:0]            CharLetter = 8'h41;

  // input item
  typedef struct packed {
    logic signed [ValueWidth-1:0] value;
    logic [RadixWidth-1:0]        radix;
  } itrt_in_t;

  // result item
  typedef struct packed {
    logic [7:0] text_char;
    logic       last_char;
  } itrt_out_t;

  // request to the divide unit
  typedef struct packed {
    logic                  start;
    logic [ValueWidth-1:0] dividend;
    logic [RadixWidth-1:0] divisor;
  } itrt_div_req_t;

  // answer of the divide unit
  typedef struct packed {
    logic                  done;
    logic [ValueWidth-1:0] quotient;
    logic [DigitWidth-1:0] remainder;
  } itrt_div_res_t;

  // digit value to ascii, upper-case letters above nine
  function automatic logic [7:0] digit_char(input logic [DigitWidth-1:0] d);
    logic [7:0] c;
    if (d > 4'd9) begin
      c = CharLetter + {4'd0, d} - 8'd10;
    end else begin
      c = CharZero + {4'd0, d};
    end
    return c;
  endfunction

endpackage

/* rtl/core/integer_to_radix_text_unit.sv */
`timescale 1ns / 1ps
// each digit takes one pass through the divider (start, 8 byte steps, push), then
// the top digit is read from the stack and the first character of the item is
// registered; characters then leave at one per cycle unless the output stalls;
// up to 64 digits (radix 2), 19 in radix 10
// a new item is taken once the last character sits in the output register
// asynchronous active-low reset clears the sequencer and output valid, not the digits

module integer_to_radix_text_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  itrt_pkg::itrt_in_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output itrt_pkg::itrt_out_t out_item_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIVIDE,
    ST_FETCH,
    ST_EMIT
  } state_e;

  state_e                            state_q;
  logic [itrt_pkg::ValueWidth-1:0]   mag_q;
  logic [itrt_pkg::RadixWidth-1:0]   radix_q;
  logic                              sign_q;
  logic [itrt_pkg::CountWidth-1:0]   count_q;
  logic                              out_valid_q;
  itrt_pkg::itrt_out_t               out_item_q;

  logic                              in_accept;
  logic                              slot_free;
  logic [itrt_pkg::ValueWidth-1:0]   mag_in;
  logic [itrt_pkg::RadixWidth-1:0]   radix_in;
  logic                              push;
  logic                              pop;
  logic [itrt_pkg::DigitAddrWidth-1:0] wr_addr;
  logic [itrt_pkg::DigitAddrWidth-1:0] rd_addr;
  logic [itrt_pkg::DigitWidth-1:0]   top_digit;
  itrt_pkg::itrt_div_req_t           div_req;
  itrt_pkg::itrt_div_res_t           div_res;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;

  // magnitude in unsigned arithmetic and clamped radix
  assign mag_in = in_item_i.value[itrt_pkg::ValueWidth-1]
                ? ~in_item_i.value + 64'd1 : in_item_i.value;

  always_comb begin
    if (in_item_i.radix < itrt_pkg::RadixMin) begin
      radix_in = itrt_pkg::RadixMin;
    end else if (in_item_i.radix > itrt_pkg::RadixMax) begin
      radix_in = itrt_pkg::RadixMax;
    end else begin
      radix_in = in_item_i.radix;
    end
  end

  // divider request and digit store control
  assign div_req.start    = (state_q == ST_START);
  assign div_req.dividend = mag_q;
  assign div_req.divisor  = radix_q;

  assign push = (state_q == ST_DIVIDE) && div_res.done;
  assign pop  = (state_q == ST_EMIT) && slot_free && !sign_q;

  // digits are written upward from zero; the read port already looks at the
  // entry below the count that holds after this edge
  assign wr_addr = count_q[itrt_pkg::DigitAddrWidth-1:0];
  assign rd_addr = count_q[itrt_pkg::DigitAddrWidth-1:0]
                 - (pop ? itrt_pkg::DigitAddrWidth'(2) : itrt_pkg::DigitAddrWidth'(1));

  itrt_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .res_o  (div_res)
  );

  itrt_digit_stack #(
    .Width (itrt_pkg::DigitWidth),
    .Depth (itrt_pkg::DigitDepth)
  ) u_stack (
    .clk_i     (clk_i),
    .wr_en_i   (push),
    .wr_addr_i (wr_addr),
    .wr_data_i (div_res.remainder),
    .rd_addr_i (rd_addr),
    .rd_data_o (top_digit)
  );

  // sequencer with output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mag_q       <= '0;
      radix_q     <= '0;
      count_q     <= '0;
      sign_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            mag_q   <= mag_in;
            radix_q <= radix_in;
            sign_q  <= in_item_i.value[itrt_pkg::ValueWidth-1]
                       && (radix_in == itrt_pkg::RadixDec);
            count_q <= '0;
            state_q <= ST_START;
          end
        end
        ST_START: begin
          state_q <= ST_DIVIDE;
        end
        ST_DIVIDE: begin
          if (div_res.done) begin
            mag_q   <= div_res.quotient;
            count_q <= count_q + 1'b1;
            if ((div_res.quotient == '0)
                || (count_q == itrt_pkg::CountWidth'(itrt_pkg::DigitDepth - 1))) begin
              state_q <= ST_FETCH;
            end else begin
              state_q <= ST_START;
            end
          end
        end
        ST_FETCH: begin
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            if (sign_q) begin
              sign_q               <= 1'b0;
              out_item_q.text_char <= itrt_pkg::CharMinus;
              out_item_q.last_char <= 1'b0;
            end else begin
              out_item_q.text_char <= itrt_pkg::digit_char(top_digit);
              out_item_q.last_char <= (count_q == itrt_pkg::CountWidth'(1));
              count_q              <= count_q - 1'b1;
              if (count_q == itrt_pkg::CountWidth'(1)) begin
                state_q <= ST_IDLE;
              end
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

/* rtl/core/itrt_divider.sv */
`timescale 1ns / 1ps

// divides 64-bit magnitudes by radix 2..16, eight quotient bits per busy cycle
module itrt_divider (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  itrt_pkg::itrt_div_req_t req_i,
  output itrt_pkg::itrt_div_res_t res_o
);

  localparam int unsigned StepBits = 8;
  localparam int unsigned StepCount = itrt_pkg::ValueWidth / StepBits;
  localparam int unsigned StepCntW = $clog2(StepCount);

  logic                              busy_q;
  logic                              done_q;
  logic [StepCntW-1:0]               cnt_q;
  logic [itrt_pkg::ValueWidth-1:0]   num_q;
  logic [itrt_pkg::DigitWidth-1:0]   rem_q;
  logic [itrt_pkg::RadixWidth-1:0]   div_q;
  logic [StepBits-1:0]               qbyte;
  logic [itrt_pkg::DigitWidth-1:0]   rem_d;

  // restoring steps over the top byte of the dividend
  always_comb begin
    logic [itrt_pkg::RadixWidth-1:0] trial;
    logic [itrt_pkg::DigitWidth-1:0] rem_v;
    rem_v = rem_q;
    qbyte = '0;
    for (int b = StepBits - 1; b >= 0; b--) begin
      trial = {rem_v, num_q[itrt_pkg::ValueWidth - StepBits + b]};
      if (trial >= div_q) begin
        trial    = trial - div_q;
        qbyte[b] = 1'b1;
      end
      rem_v = trial[itrt_pkg::DigitWidth-1:0];
    end
    rem_d = rem_v;
  end

  // quotient bits shift in where dividend bits leave
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == StepCntW'(StepCount - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.dividend;
      rem_q <= '0;
      div_q <= req_i.divisor;
    end else if (busy_q) begin
      num_q <= {num_q[itrt_pkg::ValueWidth-StepBits-1:0], qbyte};
      rem_q <= rem_d;
    end
  end

  assign res_o.done      = done_q;
  assign res_o.quotient  = num_q;
  assign res_o.remainder = rem_q;

endmodule

/* rtl/core/itrt_digit_stack.sv */
`timescale 1ns / 1ps

// generic memory, one write port and one registered read port
module itrt_digit_stack #(
  parameter int unsigned Width = 4,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule
